@@ src/step_toward_point_3d_assert.svh @@
// assertion macros for the step_toward_point_3d block
// depends on nothing; taken in by the files that assert
`ifndef STEP_TOWARD_POINT_3D_ASSERT_SVH
`define STEP_TOWARD_POINT_3D_ASSERT_SVH

// same-cycle implication under active-low reset
`define STPT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("stpt assertion failed");

// next-cycle implication under active-low reset
`define STPT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("stpt assertion failed");

`endif

@@ src/stpt_pkg.sv @@
// shared types for the step_toward_point_3d block
// depends on nothing
`timescale 1ns / 1ps

package stpt_pkg;

	// bit width of the length; the sqrt radicand is twice as wide
	localparam int unsigned LenBits = 63;

	typedef struct packed {
		logic neg;
		logic reach;
	} lane_ctl_t;

endpackage

@@ src/stpt_sqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on nothing; payload rides along with the radicand
`timescale 1ns / 1ps

module stpt_sqrt #(
	parameter int RW = 126,
	parameter int PW = 8
) (
	input  logic              clk,
	input  logic              ce,
	input  logic [RW-1:0]     rad_in,
	input  logic [PW-1:0]     pay_in,
	output logic [RW/2-1:0]   root_out,
	output logic [PW-1:0]     pay_out
);

	localparam int N  = RW / 2;
	localparam int RS = N + 1;

	logic [RW-1:0] rad_q  [0:N];
	logic [N-1:0]  root_q [0:N];
	logic [RS-1:0] rem_q  [0:N];
	logic [PW-1:0] pay_q  [0:N];

	assign rad_q[0]  = rad_in;
	assign root_q[0] = '0;
	assign rem_q[0]  = '0;
	assign pay_q[0]  = pay_in;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [N+2:0] sh;
		logic [N+2:0] trial;
		logic         ge;
		logic [N+2:0] nrem;

		assign sh    = {rem_q[i], rad_q[i][RW-1-2*i -: 2]};
		assign trial = {1'b0, root_q[i], 2'b01};
		assign ge    = (sh >= trial);
		assign nrem  = ge ? (sh - trial) : sh;

		always_ff @(posedge clk) begin
			if (ce) begin
				rad_q[i+1]  <= rad_q[i];
				root_q[i+1] <= {root_q[i][N-2:0], ge};
				rem_q[i+1]  <= nrem[RS-1:0];
				pay_q[i+1]  <= pay_q[i];
			end
		end
	end

	assign root_out = root_q[N];
	assign pay_out  = pay_q[N];

endmodule

@@ src/stpt_lane.sv @@
// one coordinate lane: pipelined restoring divide, then add and saturate, or pass the target when reached
// depends on stpt_pkg
`timescale 1ns / 1ps

module stpt_lane #(
	parameter int W = 32
) (
	input  logic                       clk,
	input  logic                       ce,
	input  logic [W-1:0]               cur,
	input  logic [W-1:0]               tgt,
	input  stpt_pkg::lane_ctl_t        ctl,
	input  logic [2*W:0]               prod,
	input  logic [stpt_pkg::LenBits-1:0] len,
	output logic [W-1:0]               coord,
	output logic                       sat,
	output logic                       reach
);

	localparam int LW = stpt_pkg::LenBits;
	localparam int E  = 62 - W;
	localparam int NW = 2 * W + 1 + E;

	logic [NW-1:0] num;
	assign num = {prod, {E{1'b0}}};

	logic [LW-1:0]           rem_q [0:W];
	logic [W-1:0]            low_q [0:W];
	logic [W-1:0]            quo_q [0:W];
	logic [LW-1:0]           len_q [0:W];
	logic [W-1:0]            cur_q [0:W];
	logic [W-1:0]            tgt_q [0:W];
	stpt_pkg::lane_ctl_t     ctl_q [0:W];

	assign rem_q[0] = num[NW-1:W];
	assign low_q[0] = num[W-1:0];
	assign quo_q[0] = '0;
	assign len_q[0] = len;
	assign cur_q[0] = cur;
	assign tgt_q[0] = tgt;
	assign ctl_q[0] = ctl;

	for (genvar i = 0; i < W; i++) begin : g_div
		logic [LW:0] sh;
		logic        ge;
		logic [LW:0] nrem;

		assign sh   = {rem_q[i], low_q[i][W-1]};
		assign ge   = (sh >= {1'b0, len_q[i]});
		assign nrem = ge ? (sh - {1'b0, len_q[i]}) : sh;

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_q[i+1] <= nrem[LW-1:0];
				low_q[i+1] <= {low_q[i][W-2:0], 1'b0};
				quo_q[i+1] <= {quo_q[i][W-2:0], ge};
				len_q[i+1] <= len_q[i];
				cur_q[i+1] <= cur_q[i];
				tgt_q[i+1] <= tgt_q[i];
				ctl_q[i+1] <= ctl_q[i];
			end
		end
	end

	logic signed [W:0]   step;
	logic signed [W+1:0] sum;
	logic signed [W+1:0] hi_lim;
	logic signed [W+1:0] lo_lim;

	assign step   = ctl_q[W].neg ? -$signed({1'b0, quo_q[W]}) : $signed({1'b0, quo_q[W]});
	assign sum    = $signed({cur_q[W][W-1], cur_q[W][W-1], cur_q[W]})
		+ $signed({step[W], step});
	assign hi_lim = $signed({3'b000, {(W-1){1'b1}}});
	assign lo_lim = $signed({3'b111, {(W-1){1'b0}}});

	always_comb begin
		sat   = 1'b0;
		coord = sum[W-1:0];
		priority if (ctl_q[W].reach) begin
			coord = tgt_q[W];
		end else if (sum > hi_lim) begin
			coord = hi_lim[W-1:0];
			sat   = 1'b1;
		end else if (sum < lo_lim) begin
			coord = lo_lim[W-1:0];
			sat   = 1'b1;
		end
	end

	assign reach = ctl_q[W].reach;

endmodule

@@ src/step_toward_point_3d.sv @@
// step_toward_point_3d: moves a 3-D point toward a target by a step limit.
// Input request on s_* : s_tdata holds cur_x, cur_y, cur_z, tgt_x, tgt_y,
// tgt_z, max_step, COORD_WIDTH bits each, lowest bits first, signed Q16.16.
// Output request on m_*: m_tdata holds new_x, new_y, new_z; m_tuser holds
// reached (bit 0) and overflow (bit 1).
// Throughput: one request per cycle while the receiver keeps up. The
// pipeline has three front stages for the difference, squares and compare,
// one stage per root bit of the shared square root, one stage per quotient
// bit in each of the three coordinate lanes, and the output register where
// the lanes merge.
// Reset clears all valid bits; no request is in flight afterward and the
// block is ready at once. When the receiver stalls with a result held, the
// whole pipeline freezes and s_tready drops in the same cycle; nothing in
// flight is lost. No configuration registers.
// depends on stpt_pkg, stpt_sqrt, stpt_lane and the assertion header
`timescale 1ns / 1ps
`include "step_toward_point_3d_assert.svh"

module step_toward_point_3d #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z, max_step; zero padded
	input  logic [((7*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// new_x, new_y, new_z; zero padded
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// reached, overflow
	output logic [1:0] m_tuser
);

	localparam int W   = COORD_WIDTH;
	localparam int E   = 62 - W;
	localparam int RW  = 2 * stpt_pkg::LenBits;
	localparam int LPW = 4 * W + 2;
	localparam int PW  = 3 * LPW + 1;
	localparam int D   = 3 + stpt_pkg::LenBits + W;
	localparam int OW  = ((3*W+7)/8)*8;

	logic ce;
	logic [D-1:0] vld_q;
	logic out_vld_q;

	assign ce       = !out_vld_q || m_tready;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (ce) begin
			vld_q     <= {vld_q[D-2:0], s_tvalid};
			out_vld_q <= vld_q[D-1];
		end
	end

	// front stages
	logic [W-1:0]      cur_s1 [0:2], cur_s2 [0:2], cur_s3 [0:2];
	logic [W-1:0]      tgt_s1 [0:2], tgt_s2 [0:2], tgt_s3 [0:2];
	logic              neg_s1 [0:2], neg_s2 [0:2], neg_s3 [0:2];
	logic [W:0]        mag_s1 [0:2];
	logic [2*W+1:0]    sq_s2  [0:2];
	logic [2*W:0]      pr_s2  [0:2], pr_s3 [0:2];
	logic [W-1:0]      mm_s1;
	logic              mneg_s1, mneg_s2;
	logic [2*W-1:0]    mm_s2;
	logic              reach_s3;
	logic [RW-1:0]     rad_s3;

	logic signed [W-1:0] m_in;
	assign m_in = $signed(s_tdata[6*W +: W]);

	for (genvar i = 0; i < 3; i++) begin : g_front
		logic signed [W:0] d;
		assign d = $signed({s_tdata[(3+i)*W+W-1], s_tdata[(3+i)*W +: W]})
			- $signed({s_tdata[i*W+W-1], s_tdata[i*W +: W]});

		always_ff @(posedge clk) begin
			if (ce) begin
				cur_s1[i] <= s_tdata[i*W +: W];
				tgt_s1[i] <= s_tdata[(3+i)*W +: W];
				neg_s1[i] <= d[W] ^ m_in[W-1];
				mag_s1[i] <= d[W] ? (W+1)'(0) - (W+1)'(d) : (W+1)'(d);
				cur_s2[i] <= cur_s1[i];
				tgt_s2[i] <= tgt_s1[i];
				neg_s2[i] <= neg_s1[i];
				sq_s2[i]  <= (2*W+2)'(mag_s1[i]) * (2*W+2)'(mag_s1[i]);
				pr_s2[i]  <= (2*W+1)'(mag_s1[i]) * (2*W+1)'(mm_s1);
				cur_s3[i] <= cur_s2[i];
				tgt_s3[i] <= tgt_s2[i];
				neg_s3[i] <= neg_s2[i];
				pr_s3[i]  <= pr_s2[i];
			end
		end
	end

	logic [2*W+1:0] ssum;
	assign ssum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk) begin
		if (ce) begin
			mneg_s1  <= m_in[W-1];
			mm_s1    <= m_in[W-1] ? W'(0) - W'(m_in) : W'(m_in);
			mneg_s2  <= mneg_s1;
			mm_s2    <= (2*W)'(mm_s1) * (2*W)'(mm_s1);
			reach_s3 <= (ssum == '0) || (!mneg_s2 && ssum <= (2*W+2)'(mm_s2));
			rad_s3   <= {ssum, {(2*E){1'b0}}};
		end
	end

	// shared length
	logic [PW-1:0] pay_in, pay_out;
	logic [stpt_pkg::LenBits-1:0] len;

	for (genvar i = 0; i < 3; i++) begin : g_pack
		assign pay_in[i*LPW +: LPW] = {pr_s3[i], neg_s3[i], tgt_s3[i], cur_s3[i]};
	end
	assign pay_in[PW-1] = reach_s3;

	stpt_sqrt #(.RW(RW), .PW(PW)) u_sqrt (
		.clk      (clk),
		.ce       (ce),
		.rad_in   (rad_s3),
		.pay_in   (pay_in),
		.root_out (len),
		.pay_out  (pay_out)
	);

	// lanes and merge
	logic [W-1:0] coord [0:2];
	logic [2:0]   sat;
	logic [2:0]   reach;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		stpt_pkg::lane_ctl_t ctl;
		assign ctl.neg   = pay_out[i*LPW + 2*W];
		assign ctl.reach = pay_out[PW-1];

		stpt_lane #(.W(W)) u_lane (
			.clk   (clk),
			.ce    (ce),
			.cur   (pay_out[i*LPW +: W]),
			.tgt   (pay_out[i*LPW + W +: W]),
			.ctl   (ctl),
			.prod  (pay_out[i*LPW + 2*W + 1 +: 2*W+1]),
			.len   (len),
			.coord (coord[i]),
			.sat   (sat[i]),
			.reach (reach[i])
		);
	end

	logic [OW-1:0] data_q;
	logic [1:0]    user_q;

	always_ff @(posedge clk) begin
		if (ce) begin
			data_q <= OW'({coord[2], coord[1], coord[0]});
			user_q <= {|sat, &reach};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

	`STPT_ASSERT_IMPLY(a_reach_no_ovf, clk, arst_n, m_tvalid && m_tuser[0], !m_tuser[1])
	`STPT_ASSERT_IMPLY(a_stall_blocks, clk, arst_n, m_tvalid && !m_tready, !s_tready)
	`STPT_ASSERT_NEXT(a_out_from_pipe, clk, arst_n, !m_tvalid && !vld_q[D-1], !m_tvalid)

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for step_toward_point_3d: directed and random point
// updates, random source and sink idling, one long sink stall, in-order checks
// depends on the step_toward_point_3d rtl
`timescale 1ns / 1ps

module tb_top;

	localparam int CW = 32;
	localparam int XB = 62 - CW;
	localparam longint HI = 64'sd2147483647;
	localparam longint LO = -64'sd2147483648;
	localparam int LIMIT = 300000;
	localparam int N_RAND = 450;

	typedef struct {
		logic signed [31:0] cur [3];
		logic signed [31:0] tgt [3];
		logic signed [31:0] lim;
	} move_req_t;

	typedef struct {
		logic [31:0] pos [3];
		logic reached;
		logic overflow;
	} move_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [223:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0] m_tuser;

	move_req_t pending_q[$];
	move_res_t expected_q[$];
	int errors = 0;
	int n_sent = 0;
	int cyc = 0;
	int src_gap = 0;
	int snk_gap = 0;
	int hold_cnt = 0;
	bit hold_done = 0;
	bit quiet = 0;

	always #5 clk = ~clk;

	step_toward_point_3d #(.COORD_WIDTH(CW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	function automatic logic [63:0] root_len(logic [127:0] x);
		logic [63:0] res;
		logic [63:0] c;
		logic [127:0] cc;
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (64'd1 << b);
			cc = {64'd0, c} * {64'd0, c};
			if (cc <= x) res = c;
		end
		return res;
	endfunction

	function automatic move_res_t step_point(move_req_t r);
		move_res_t o;
		longint d [3];
		logic [63:0] ad [3];
		logic [63:0] am;
		logic [127:0] sq;
		logic [127:0] lim_sq;
		logic [127:0] num;
		logic [63:0] len;
		logic [63:0] q;
		longint stp;
		longint nv;
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'(r.tgt[i]) - longint'(r.cur[i]);
			ad[i] = d[i] < 0 ? -d[i] : d[i];
			sq += {64'd0, ad[i]} * {64'd0, ad[i]};
		end
		am = r.lim < 0 ? -longint'(r.lim) : longint'(r.lim);
		lim_sq = {64'd0, am} * {64'd0, am};
		o.overflow = 1'b0;
		if (sq == 0 || (r.lim >= 0 && sq <= lim_sq)) begin
			for (int i = 0; i < 3; i++) o.pos[i] = r.tgt[i];
			o.reached = 1'b1;
			return o;
		end
		o.reached = 1'b0;
		len = root_len(sq << (2 * XB));
		for (int i = 0; i < 3; i++) begin
			num = ({64'd0, ad[i]} * {64'd0, am}) << XB;
			q = 64'(num / {64'd0, len});
			stp = ((d[i] < 0) != (r.lim < 0)) ? -longint'(q) : longint'(q);
			nv = longint'(r.cur[i]) + stp;
			if (nv > HI) begin
				nv = HI;
				o.overflow = 1'b1;
			end
			if (nv < LO) begin
				nv = LO;
				o.overflow = 1'b1;
			end
			o.pos[i] = nv[31:0];
		end
		return o;
	endfunction

	function automatic logic signed [31:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 32'hffff)
				: 32'sh80000000 + $urandom_range(0, 32'hffff);
			default: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
		endcase
	endfunction

	function automatic move_req_t rnd_req();
		move_req_t r;
		int mode;
		mode = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			r.cur[i] = rnd_coord(mode);
			r.tgt[i] = $urandom_range(0, 5) == 0 ? r.cur[i] : rnd_coord(mode);
		end
		case ($urandom_range(0, 4))
			0: r.lim = $urandom;
			1: r.lim = $urandom_range(0, 32'h3ffff);
			2: r.lim = -$signed($urandom_range(0, 32'h3ffff));
			3: r.lim = $signed($urandom_range(0, 32'h7fffffff));
			default: r.lim = rnd_coord(mode);
		endcase
		return r;
	endfunction

	function automatic move_req_t mk_req(logic signed [31:0] cx, logic signed [31:0] cy,
		logic signed [31:0] cz, logic signed [31:0] tx, logic signed [31:0] ty,
		logic signed [31:0] tz, logic signed [31:0] l);
		move_req_t r;
		r.cur[0] = cx; r.cur[1] = cy; r.cur[2] = cz;
		r.tgt[0] = tx; r.tgt[1] = ty; r.tgt[2] = tz;
		r.lim = l;
		return r;
	endfunction

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_q.push_back(step_point(pending_q[0]));
				void'(pending_q.pop_front());
				n_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (src_gap > 0)
					src_gap--;
				else if (!quiet && $urandom_range(0, 9) == 0)
					src_gap = $urandom_range(1, 11);
				if (src_gap == 0 && pending_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {pending_q[0].lim, pending_q[0].tgt[2], pending_q[0].tgt[1],
						pending_q[0].tgt[0], pending_q[0].cur[2], pending_q[0].cur[1],
						pending_q[0].cur[0]};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side, with one long hold-off to back up the pipeline
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (!hold_done && n_sent >= 150 && hold_cnt == 0)
				hold_cnt = 400;
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0) hold_done = 1;
				m_tready <= 1'b0;
			end else begin
				if (snk_gap > 0)
					snk_gap--;
				else if (!quiet && $urandom_range(0, 9) == 0)
					snk_gap = $urandom_range(1, 11);
				m_tready <= (snk_gap == 0);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		move_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected: %h %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = expected_q.pop_front();
				for (int i = 0; i < 3; i++)
					if (m_tdata[32*i +: 32] !== e.pos[i]) begin
						$display("%0t: coord %0d expected %h actual %h", $time, i, e.pos[i],
							m_tdata[32*i +: 32]);
						errors++;
					end
				if (m_tuser[0] !== e.reached) begin
					$display("%0t: reached expected %b actual %b", $time, e.reached, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== e.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time, e.overflow,
						m_tuser[1]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc == LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		// zero difference, any limit
		pending_q.push_back(mk_req(5, -7, 9, 5, -7, 9, -32'sd65536));
		pending_q.push_back(mk_req(0, 0, 0, 0, 0, 0, 0));
		// exact reach, just short, then short of a diagonal target
		pending_q.push_back(mk_req(0, 0, 0, 32'sh30000, 32'sh40000, 0, 32'sh50000));
		pending_q.push_back(mk_req(0, 0, 0, 32'sh30000, 32'sh40000, 0, 32'sh4ffff));
		pending_q.push_back(mk_req(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000));
		// zero limit with distance
		pending_q.push_back(mk_req(1, 2, 3, 100, 200, 300, 0));
		// negative limit moves away
		pending_q.push_back(mk_req(0, 0, 0, 32'sh10000, 0, 0, -32'sh20000));
		pending_q.push_back(mk_req(1, 1, 1, 1, 1, 2, 32'sh80000000));
		// rounding leaves the point short of the target in the moving branch
		pending_q.push_back(mk_req(0, 0, 0, 3, 3, 3, 5));
		// extremes and saturation
		pending_q.push_back(mk_req(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		pending_q.push_back(mk_req(32'sh7fffffff, 32'sh80000000, 0,
			32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff));
		pending_q.push_back(mk_req(32'sh7fff0000, 32'sh80010000, 0,
			32'sh7fff0001, 32'sh80010000, 0, 32'sh80000000));
		pending_q.push_back(mk_req(32'sh80000000, 0, 32'sh7fffffff,
			32'sh80000001, 0, 32'sh7ffffffe, 32'sh80000000));
		pending_q.push_back(mk_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 1));
		pending_q.push_back(mk_req(-1, -1, -1, 0, 0, 0, -1));
		pending_q.push_back(mk_req(32'shffffffff, 32'shaaaaaaaa, 32'sh55555555,
			32'sh55555555, 32'shffffffff, 32'shaaaaaaaa, 32'sh12345678));
		for (int i = 0; i < N_RAND; i++) pending_q.push_back(rnd_req());
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() < 60);
		quiet = 1;
		wait (pending_q.size() == 0 && !s_tvalid && expected_q.size() == 0);
		repeat (120) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
